// File: rtl/liu_pkg.sv
// Shared constants and types for the linear interpolation upsampler.
`default_nettype none

package liu_pkg;

   localparam int LANES       = 6;
   localparam int SAMPLE_BITS = 32;
   localparam int MAX_FACTOR  = 32;
   localparam int CSR_BITS    = 6;
   localparam int FACTOR_BITS = $clog2(MAX_FACTOR + 1);
   localparam int ROW_BITS    = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
   localparam int DIFF_BITS   = SAMPLE_BITS + 1;
   localparam int DIV_STEPS   = DIFF_BITS;
   localparam int CNT_BITS    = $clog2(DIV_STEPS);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [FACTOR_BITS-1:0]        factor_type;

   typedef struct packed {
      logic load;
      logic div;
      logic step;
   } lane_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

`default_nettype wire

// File: rtl/linear_interp_upsampler.sv
// Top level: sequencer, held samples, six interpolation lanes and the output register.
//
// Input beats on req_* carry one time step of six samples and a last-step flag;
// result beats on rsp_* carry one interpolated output step. Both use valid/ready.
// csr_wr_en/csr_wr_data set the factor L (0 acts as 1, above 32 acts as 32);
// write it only while the block is idle.
// The first step of a series is held and yields nothing unless it is also a
// last step; it is taken while the block stays idle. Every later step yields
// one interval of L beats; a last step adds one more interval toward zero.
// Each interval costs a serial divide of the sample delta by L (one quotient
// bit per cycle, all lanes at once), then output at one beat per cycle while
// the receiver takes them. Reset drops the held sample, clears the pending
// output beat and sets L to 1. While the receiver stalls, the output
// register holds its beat and the lanes hold their position; req_ready stays
// low until the item finishes.
`default_nettype none

module linear_interp_upsampler
   import liu_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [CSR_BITS-1:0] csr_wr_data,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire sample_type          req_comp_0,
   input  wire sample_type          req_comp_1,
   input  wire sample_type          req_comp_2,
   input  wire sample_type          req_comp_3,
   input  wire sample_type          req_comp_4,
   input  wire sample_type          req_comp_5,
   input  wire logic                req_last_step,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output sample_type               rsp_out_0,
   output sample_type               rsp_out_1,
   output sample_type               rsp_out_2,
   output sample_type               rsp_out_3,
   output sample_type               rsp_out_4,
   output sample_type               rsp_out_5,
   output logic                     rsp_run_end,
   output logic                     rsp_series_end
);

   state_type             state_ff, state_in;
   logic [CSR_BITS-1:0]   factor_ff, factor_in;
   logic                  have_held_ff, have_held_in;
   logic                  phase_ff, phase_in;
   logic                  last_ff, last_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [ROW_BITS-1:0]   r_ff, r_in;
   sample_type            held_ff [LANES];
   sample_type            held_in [LANES];
   sample_type            cur_ff [LANES];
   sample_type            cur_in [LANES];

   sample_type            req_comp [LANES];
   sample_type            lane_a [LANES];
   sample_type            lane_b [LANES];
   sample_type            lane_val [LANES];
   sample_type            out_val [LANES];
   lane_ctrl_type         lane_ctrl;
   factor_type            l_eff;
   logic                  row_end;
   logic                  can_push;
   logic                  push;
   logic                  run_end;
   logic                  series_end;

   assign req_comp[0] = req_comp_0;
   assign req_comp[1] = req_comp_1;
   assign req_comp[2] = req_comp_2;
   assign req_comp[3] = req_comp_3;
   assign req_comp[4] = req_comp_4;
   assign req_comp[5] = req_comp_5;

   always_comb begin
      priority if (factor_ff == '0) begin
         l_eff = FACTOR_BITS'(1);
      end else if (CSR_BITS'(factor_ff) > CSR_BITS'(MAX_FACTOR)) begin
         l_eff = FACTOR_BITS'(MAX_FACTOR);
      end else begin
         l_eff = FACTOR_BITS'(factor_ff);
      end
   end

   assign row_end   = FACTOR_BITS'(r_ff) == FACTOR_BITS'(l_eff - 1'b1);
   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (state_ff == ST_IDLE) begin
            lane_a[i] = have_held_ff ? held_ff[i] : req_comp[i];
            lane_b[i] = have_held_ff ? req_comp[i] : '0;
         end else begin
            lane_a[i] = cur_ff[i];
            lane_b[i] = '0;
         end
      end
   end

   always_comb begin
      factor_in    = csr_wr_en ? csr_wr_data : factor_ff;
      state_in     = state_ff;
      have_held_in = have_held_ff;
      phase_in     = phase_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      r_in         = r_ff;
      held_in      = held_ff;
      cur_in       = cur_ff;
      lane_ctrl    = '0;
      push         = 1'b0;
      run_end      = 1'b0;
      series_end   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in       = req_comp;
               last_in      = req_last_step;
               have_held_in = !req_last_step;
               if (!req_last_step) begin
                  held_in = req_comp;
               end
               if (have_held_ff || req_last_step) begin
                  lane_ctrl.load = 1'b1;
                  phase_in       = !have_held_ff;
                  cnt_in         = '0;
                  state_in       = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            lane_ctrl.div = 1'b1;
            cnt_in        = CNT_BITS'(cnt_ff + 1'b1);
            if (cnt_ff == CNT_BITS'(DIV_STEPS - 1)) begin
               r_in     = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (can_push) begin
               push           = 1'b1;
               lane_ctrl.step = 1'b1;
               r_in           = ROW_BITS'(r_ff + 1'b1);
               if (row_end) begin
                  run_end    = phase_ff || !last_ff;
                  series_end = phase_ff && last_ff;
                  if (!phase_ff && last_ff) begin
                     lane_ctrl.load = 1'b1;
                     phase_in       = 1'b1;
                     cnt_in         = '0;
                     state_in       = ST_DIV;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         factor_ff    <= CSR_BITS'(1);
         have_held_ff <= 1'b0;
         phase_ff     <= 1'b0;
         last_ff      <= 1'b0;
         cnt_ff       <= '0;
         r_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         factor_ff    <= factor_in;
         have_held_ff <= have_held_in;
         phase_ff     <= phase_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         r_ff         <= r_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      cur_ff  <= cur_in;
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      liu_lane u_lane (
         .clock  (clock),
         .ctrl   (lane_ctrl),
         .factor (l_eff),
         .a_val  (lane_a[g]),
         .b_val  (lane_b[g]),
         .value  (lane_val[g])
      );
   end

   liu_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .lane_val       (lane_val),
      .run_end        (run_end),
      .series_end     (series_end),
      .can_push       (can_push),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .out_val        (out_val),
      .rsp_run_end    (rsp_run_end),
      .rsp_series_end (rsp_series_end)
   );

   assign rsp_out_0 = out_val[0];
   assign rsp_out_1 = out_val[1];
   assign rsp_out_2 = out_val[2];
   assign rsp_out_3 = out_val[3];
   assign rsp_out_4 = out_val[4];
   assign rsp_out_5 = out_val[5];

   a_series_end_is_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_series_end |-> rsp_run_end)
      else $error("series end beat without run end");

   a_tail_interval_follows: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && push && row_end && !phase_ff && last_ff
      |=> state_ff == ST_DIV && phase_ff)
      else $error("tail interval of a last step not started");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> FACTOR_BITS'(r_ff) < l_eff)
      else $error("output row beyond factor");

   a_no_hold_after_series: assert property (@(posedge clock) disable iff (reset)
      push && series_end |=> !have_held_ff && state_ff == ST_IDLE)
      else $error("sample still held after series end");

endmodule

`default_nettype wire

// File: rtl/liu_lane.sv
// One interpolation lane: serial divide of the step delta, then incremental accumulate.
`default_nettype none

module liu_lane
   import liu_pkg::*;
(
   input  wire logic          clock,
   input  wire lane_ctrl_type ctrl,
   input  wire factor_type    factor,
   input  wire sample_type    a_val,
   input  wire sample_type    b_val,
   output sample_type         value
);

   sample_type                 a_ff, a_in;
   logic                       neg_ff, neg_in;
   logic                       zero_ff, zero_in;
   logic                       first_ff, first_in;
   logic [DIFF_BITS-1:0]       quo_ff, quo_in;
   logic [FACTOR_BITS-1:0]     rem_ff, rem_in;
   logic [DIFF_BITS-1:0]       acc_q_ff, acc_q_in;
   logic [FACTOR_BITS-1:0]     acc_r_ff, acc_r_in;

   logic signed [DIFF_BITS-1:0] diff;
   logic [DIFF_BITS-1:0]        mag;
   logic [FACTOR_BITS:0]        shifted;
   logic [FACTOR_BITS:0]        factor_ext;
   logic                        fits;
   logic [FACTOR_BITS:0]        rsum;
   logic                        carry;
   logic [SAMPLE_BITS-1:0]      offs;

   assign diff       = DIFF_BITS'(b_val) - DIFF_BITS'(a_val);
   assign mag        = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
   assign factor_ext = {1'b0, factor};
   assign shifted    = {rem_ff, quo_ff[DIFF_BITS-1]};
   assign fits       = shifted >= factor_ext;
   assign rsum       = {1'b0, acc_r_ff} + {1'b0, rem_ff};
   assign carry      = rsum >= factor_ext;

   always_comb begin
      a_in     = a_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      first_in = first_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      acc_q_in = acc_q_ff;
      acc_r_in = acc_r_ff;
      priority if (ctrl.load) begin
         a_in     = a_val;
         neg_in   = diff[DIFF_BITS-1];
         zero_in  = (a_val == '0) || (b_val == '0);
         first_in = 1'b1;
         quo_in   = mag;
         rem_in   = '0;
         acc_q_in = '0;
         acc_r_in = '0;
      end else if (ctrl.div) begin
         quo_in = {quo_ff[DIFF_BITS-2:0], fits};
         rem_in = fits ? FACTOR_BITS'(shifted - factor_ext) : FACTOR_BITS'(shifted);
      end else if (ctrl.step) begin
         first_in = 1'b0;
         acc_r_in = carry ? FACTOR_BITS'(rsum - factor_ext) : FACTOR_BITS'(rsum);
         acc_q_in = acc_q_ff + quo_ff + DIFF_BITS'(carry);
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      neg_ff   <= neg_in;
      zero_ff  <= zero_in;
      first_ff <= first_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      acc_q_ff <= acc_q_in;
      acc_r_ff <= acc_r_in;
   end

   assign offs = neg_ff ? SAMPLE_BITS'(-acc_q_ff[SAMPLE_BITS-1:0])
                        : acc_q_ff[SAMPLE_BITS-1:0];

   always_comb begin
      priority if (first_ff) begin
         value = a_ff;
      end else if (zero_ff) begin
         value = '0;
      end else begin
         value = sample_type'(a_ff + offs);
      end
   end

endmodule

`default_nettype wire

// File: rtl/liu_merge.sv
// Output register that packs the lane values and flags into one result beat.
`default_nettype none

module liu_merge
   import liu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire sample_type lane_val [LANES],
   input  wire logic       run_end,
   input  wire logic       series_end,
   output logic            can_push,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output sample_type      out_val [LANES],
   output logic            rsp_run_end,
   output logic            rsp_series_end
);

   logic       valid_ff, valid_in;
   sample_type val_ff [LANES];
   logic       run_end_ff;
   logic       series_end_ff;

   assign can_push = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         val_ff        <= lane_val;
         run_end_ff    <= run_end;
         series_end_ff <= series_end;
      end
   end

   assign rsp_valid      = valid_ff;
   assign out_val        = val_ff;
   assign rsp_run_end    = run_end_ff;
   assign rsp_series_end = series_end_ff;

endmodule

`default_nettype wire
